[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the word-wide modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  // widest supported data word and default width
  localparam int unsigned WORD_BITS_DEF = 32;

  // register reset values
  localparam logic [31:0] MODULUS_RST  = 32'd2759063089;
  localparam logic [31:0] EXPONENT_RST = 32'h0001_0001;

  // modular multiply operation currently run by the datapath
  typedef enum logic [1:0] {
    OP_RED = 2'd0,  // reduce the input word: word * 1 mod n
    OP_MUL = 2'd1,  // acc * base mod n
    OP_SQR = 2'd2   // base * base mod n
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new item, start reduction
    logic start;      // start a modular multiply of kind op
    op_e  op;
    logic step;       // one multiplier bit of the running multiply
    logic shift_key;  // drop the lowest exponent bit
    logic out_load;   // copy the result into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_last;       // current step is the last multiplier bit
    logic key_zero;       // no exponent bits left
    logic key_bit0;       // lowest exponent bit
    logic key_rest_zero;  // all bits above the lowest are zero
  } sts_t;

endpackage
`default_nettype wire

[rtl/mexp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_dp
// datapath: operand registers and a bit-serial interleaved modular multiplier
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mexp_pkg::cmd_t cmd_i,
  output mexp_pkg::sts_t     sts_o,
  input  wire logic [31:0]   modulus_i,
  input  wire logic [31:0]   exponent_i,
  input  wire logic [31:0]   plain_i,
  input  wire logic          last_i,
  output logic [31:0]        cipher_o,
  output logic               last_o
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  op_e                  op_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [WORD_BITS-1:0] acc_q, base_q, key_q, r_q, mplier_q;
  logic                 last_q;
  logic [31:0]          cipher_q;
  logic                 last_out_q;

  logic [WORD_BITS-1:0] m_w, mcand, r_d;
  logic [WORD_BITS:0]   m_ext, t2, t1, addend, s0, s1;
  logic                 cnt_last;

  // a modulus of zero stands for 2^WORD_BITS
  assign m_w   = modulus_i[WORD_BITS-1:0];
  assign m_ext = {(m_w == '0), m_w};

  assign mcand = (op_q == OP_RED) ? WORD_BITS'(1) : base_q;

  // r = 2r mod n, then r = r + b mod n when the multiplier bit is set
  always_comb begin
    t2     = {r_q, 1'b0};
    t1     = (t2 >= m_ext) ? (t2 - m_ext) : t2;
    addend = mplier_q[WORD_BITS-1] ? {1'b0, mcand} : '0;
    s0     = t1 + addend;
    s1     = (s0 >= m_ext) ? (s0 - m_ext) : s0;
    r_d    = s1[WORD_BITS-1:0];
  end

  assign cnt_last = (cnt_q == CNT_W'(WORD_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_RED;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      op_q  <= OP_RED;
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q      <= '0;
      mplier_q <= plain_i[WORD_BITS-1:0];
      key_q    <= exponent_i[WORD_BITS-1:0];
      acc_q    <= WORD_BITS'(1);
      last_q   <= last_i;
    end else if (cmd_i.start) begin
      r_q      <= '0;
      mplier_q <= (cmd_i.op == OP_MUL) ? acc_q : base_q;
    end else if (cmd_i.step) begin
      r_q      <= r_d;
      mplier_q <= {mplier_q[WORD_BITS-2:0], 1'b0};
      if (cnt_last) begin
        case (op_q)
          OP_MUL:  acc_q  <= r_d;
          default: base_q <= r_d;
        endcase
      end
    end
    if (cmd_i.shift_key) begin
      key_q <= {1'b0, key_q[WORD_BITS-1:1]};
    end
    if (cmd_i.out_load) begin
      cipher_q   <= 32'(acc_q);
      last_out_q <= last_q;
    end
  end

  assign sts_o.cnt_last      = cnt_last;
  assign sts_o.key_zero      = (key_q == '0);
  assign sts_o.key_bit0      = key_q[0];
  assign sts_o.key_rest_zero = (key_q[WORD_BITS-1:1] == '0);

  assign cipher_o = cipher_q;
  assign last_o   = last_out_q;

endmodule
`default_nettype wire

[rtl/mexp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for right-to-left square-and-multiply and the output handshake
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mexp_pkg::cmd_t      cmd_o,
  input  wire mexp_pkg::sts_t sts_i
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN_E = 3'd1;  // multiply, then evaluate a key bit
  localparam logic [2:0] S_RUN_S = 3'd2;  // multiply, then shift the key
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    cmd.op     = OP_RED;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_RUN_E;
        end
      end
      S_RUN_E: begin
        cmd.step = 1'b1;
        if (sts_i.cnt_last) state_d = S_EVAL;
      end
      S_RUN_S: begin
        cmd.step = 1'b1;
        if (sts_i.cnt_last) state_d = S_SHIFT;
      end
      S_EVAL: begin
        if (sts_i.key_zero) begin
          state_d = S_DONE;
        end else if (sts_i.key_bit0) begin
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          state_d   = S_RUN_S;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_key = 1'b1;
        if (sts_i.key_rest_zero) begin
          state_d = S_DONE;
        end else begin
          cmd.start = 1'b1;
          cmd.op    = OP_SQR;
          state_d   = S_RUN_E;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while an item is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before it was taken");

  a_mul_then_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN_S && sts_i.cnt_last) |=> (state_q == S_SHIFT))
    else $error("multiply did not hand over to the key shift");

endmodule
`default_nettype wire

[rtl/modular_exponentiation_word.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_word
// word-wide modular exponentiation, result = word ^ exponent mod modulus
// ----------------------------------------------------------------------------
// usage
//   s_axis: one item per word, tdata = plain word, tlast = end-of-buffer flag
//   m_axis: one item per input, tdata = result word, tlast = copied flag
//   apb: modulus at 0x0, exponent at 0x4, written by the user only while
//   the block is idle; the block itself does not enforce it
// timing, from accept to result register
//   grows with the bit length and popcount of the exponent, set by the
//   bit-serial modular multiplier, one multiplier bit per cycle, shared by
//   the input reduction, multiplies and squarings
// throughput
//   one item at a time; the next item is taken while a finished result
//   still waits in the output register
// reset
//   registers return to modulus 2759063089 and exponent 0x10001, no item
//   is held, m_axis_tvalid is low
// stall
//   a result waiting on m_axis_tready holds; a finished word waits in the
//   sequencer until the output register is free
// ----------------------------------------------------------------------------
module modular_exponentiation_word #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] plain_word
  input  wire logic        s_axis_tlast,   // last_word
  // result item stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] cipher_word
  output logic             m_axis_tlast,   // last_out
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mexp_pkg::*;

  // register indexes, taken from the word address
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  logic [31:0] modulus_q, exponent_q;
  logic        reg_idx;
  logic        cfg_wr;

  cmd_t cmd;
  sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RST;
      exponent_q <= EXPONENT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODULUS:  modulus_q  <= pwdata;
        REG_EXPONENT: exponent_q <= pwdata;
        default:      modulus_q  <= modulus_q;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_MODULUS:  prdata = modulus_q;
      REG_EXPONENT: prdata = exponent_q;
      default:      prdata = '0;
    endcase
  end

  // sequencer
  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // operand registers and modular multiplier
  mexp_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .modulus_i  (modulus_q),
    .exponent_i (exponent_q),
    .plain_i    (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .cipher_o   (m_axis_tdata),
    .last_o     (m_axis_tlast)
  );

endmodule
`default_nettype wire
